// ----- rtl/core/nps_pkg.sv -----
package nps_pkg;

  // search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } nps_state_t;

  typedef logic [3:0] wheel_pos_t;
  typedef logic [2:0] wheel_step_t;

  // wheel position after the last entry loops back to the first mod-30 step
  localparam wheel_pos_t WHEEL_FIRST = 4'd0;
  localparam wheel_pos_t WHEEL_LAST  = 4'd10;
  localparam wheel_pos_t WHEEL_LOOP  = 4'd3;

  // divisor increments: 2 -> 3 -> 5 -> 7, then the mod-30 wheel
  function automatic wheel_step_t wheel_step(input wheel_pos_t pos);
    wheel_step_t step;
    case (pos)
      4'd0:    step = 3'd1;
      4'd1:    step = 3'd2;
      4'd2:    step = 3'd2;
      4'd3:    step = 3'd4;
      4'd4:    step = 3'd2;
      4'd5:    step = 3'd4;
      4'd6:    step = 3'd2;
      4'd7:    step = 3'd4;
      4'd8:    step = 3'd6;
      4'd9:    step = 3'd2;
      4'd10:   step = 3'd6;
      default: step = 3'd0;
    endcase
    return step;
  endfunction

endpackage

// ----- rtl/core/nps_div.sv -----
module nps_div
  import nps_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] dq_r, dq_nxt;
  logic [VALUE_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial    = {rem_r, dq_r[VALUE_WIDTH-1]};
    diff     = trial - {1'b0, dvs_r};
    fits     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(VALUE_WIDTH - 1);
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      dq_nxt  = {dq_r[VALUE_WIDTH-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = dq_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/core/next_prime_search_core.sv -----
// flow: an even start of 2 or less needs no division; otherwise each trial divisor
//   takes one pass through the shared radix-2 divider, over all candidates tried
// throughput: one item at a time, the next item is taken once the search is back idle
// reset: rst_n synchronous active low, clears the sequencer and the output valid
module next_prime_search_core
  import nps_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_start_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_prime,
  output logic        out_overflow
);

  // largest candidate that may still grow by two
  localparam logic [VALUE_WIDTH-1:0] CAND_LIMIT =
    {VALUE_WIDTH{1'b1}} - VALUE_WIDTH'(2);

  nps_state_t             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] cand_r, cand_nxt;   // current candidate
  logic [VALUE_WIDTH-1:0] dvs_r, dvs_nxt;     // current trial divisor
  wheel_pos_t             pos_r, pos_nxt;     // place on the divisor wheel
  logic                   ovf_r, ovf_nxt;     // search ran past the width
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            out_prime_r, out_prime_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic [VALUE_WIDTH-1:0] start_w;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [VALUE_WIDTH-1:0] div_rem;

  // only the low VALUE_WIDTH bits of the start value take part
  assign start_w = VALUE_WIDTH'(in_start_value);

  // shared divider: one quotient and remainder per trial divisor
  nps_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cand_nxt),
    .divisor  (dvs_nxt),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    dvs_nxt       = dvs_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    div_start     = 1'b0;
    // output register drains independently of the search
    out_valid_nxt = out_valid_r && !out_ready;
    out_prime_nxt = out_prime_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ovf_nxt = 1'b0;
          if (!start_w[0] && (start_w <= VALUE_WIDTH'(2))) begin
            // zero and two both give two, no division needed
            cand_nxt  = VALUE_WIDTH'(2);
            state_nxt = ST_FINISH;
          end else begin
            // even starts move up to the next odd value
            cand_nxt  = start_w[0] ? start_w : start_w + VALUE_WIDTH'(1);
            dvs_nxt   = VALUE_WIDTH'(2);
            pos_nxt   = WHEEL_FIRST;
            div_start = 1'b1;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (div_done) begin
          if (div_quot < dvs_r) begin
            // divisor past the square root: candidate is prime
            state_nxt = ST_FINISH;
          end else if (div_rem == '0) begin
            if (cand_r > CAND_LIMIT) begin
              ovf_nxt   = 1'b1;
              state_nxt = ST_FINISH;
            end else begin
              // composite: next odd candidate, divisors restart at two
              cand_nxt  = cand_r + VALUE_WIDTH'(2);
              dvs_nxt   = VALUE_WIDTH'(2);
              pos_nxt   = WHEEL_FIRST;
              div_start = 1'b1;
            end
          end else begin
            // step the divisor along the wheel
            dvs_nxt   = dvs_r + VALUE_WIDTH'(wheel_step(pos_r));
            pos_nxt   = (pos_r == WHEEL_LAST) ? WHEEL_LOOP : pos_r + 4'd1;
            div_start = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = ovf_r ? 32'd0 : 32'(cand_r);
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    dvs_r       <= dvs_nxt;
    pos_r       <= pos_nxt;
    ovf_r       <= ovf_nxt;
    out_prime_r <= out_prime_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_prime    = out_prime_r;
  assign out_overflow = out_ovf_r;

  // overflow item always carries a zero prime
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_prime == 32'd0))
    else $error("overflow item with non-zero prime");

  // divider results only arrive while searching
  a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_SEARCH))
    else $error("divider done outside search");

  // search only ever runs on odd candidates with a divisor of at least two
  a_odd_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (cand_r[0] && (dvs_r >= VALUE_WIDTH'(2))))
    else $error("bad candidate or divisor in search");

  // wheel position stays within the step table
  a_wheel_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (pos_r <= WHEEL_LAST))
    else $error("wheel position out of range");

  // a waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_prime) && $stable(out_overflow)))
    else $error("pending output item changed");

endmodule

// ----- bench/next_prime_checker.sv -----
`timescale 1ns / 100ps

module next_prime_checker
  import nps_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_start_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_prime,
  input  logic        out_overflow,
  output int          fail_count,
  output int          results_owed
);

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] prime;
    logic        overflow;
  } prime_result_t;

  // largest value the search may hold; a shift by 64 wraps to all ones as well
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 64'd1;

  // divisor increments by wheel position, position 0 in the low bits
  localparam logic [32:0] DIVISOR_STEPS = {3'd6, 3'd2, 3'd6, 3'd4, 3'd2, 3'd4,
                                           3'd2, 3'd4, 3'd2, 3'd2, 3'd1};

  prime_result_t owed_q[$];

  function automatic prime_result_t smallest_prime_from(input logic [31:0] start);
    longint unsigned cand;
    longint unsigned dvsr;
    wheel_pos_t      pos;
    prime_result_t   res;
    res          = '0;
    res.start    = start;
    cand         = 64'(start) & VALUE_MAX;
    if (cand[0] == 1'b0) begin
      if (cand <= 64'd2) begin
        res.prime = 32'd2;
        return res;
      end
      cand = cand + 64'd1;
    end
    dvsr = 64'd2;
    pos  = WHEEL_FIRST;
    while (cand / dvsr >= dvsr) begin
      if (cand % dvsr == 64'd0) begin
        // next odd candidate would not fit the width
        if (cand > VALUE_MAX - 64'd2) begin
          res.overflow = 1'b1;
          return res;
        end
        cand = cand + 64'd2;
        dvsr = 64'd2;
        pos  = WHEEL_FIRST;
      end else begin
        dvsr = dvsr + 64'(DIVISOR_STEPS[pos*3 +: 3]);
        if (pos == WHEEL_LAST) begin
          pos = WHEEL_LOOP;
        end else begin
          pos = pos + 4'd1;
        end
      end
    end
    res.prime = cand[31:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    prime_result_t owed;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      owed_q.delete();
      fail_count   <= 0;
      results_owed <= 0;
    end else begin
      if (in_valid && in_ready) begin
        owed_q.push_back(smallest_prime_from(in_start_value));
      end
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $error("result item with none owed: prime %0d overflow %0d",
                 out_prime, out_overflow);
          errs++;
        end else begin
          owed = owed_q.pop_front();
          if (out_prime !== owed.prime) begin
            $error("prime (start %0d): expected %0d, got %0d",
                   owed.start, owed.prime, out_prime);
            errs++;
          end
          if (out_overflow !== owed.overflow) begin
            $error("overflow (start %0d): expected %0d, got %0d",
                   owed.start, owed.overflow, out_overflow);
            errs++;
          end
        end
      end
      fail_count   <= fail_count + errs;
      results_owed <= owed_q.size();
    end
  end

endmodule

// ----- bench/tb_next_prime_search_core.sv -----
`timescale 1ns / 100ps

module tb_next_prime_search_core;

  localparam int VALUE_WIDTH  = 32;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 75;
  localparam int MAX_IDLE     = 12;
  // settling time after the last result comes back, sized from the divider width with a margin
  localparam int DRAIN_CYCLES = 2 * (VALUE_WIDTH + 1) + 4;
  // the slowest item is a composite just below 2^32 whose first factor is 9241;
  // the limit covers it and the whole random part with room to spare
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int CORNER_ITEMS = 25;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [31:0] in_start_value = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [31:0] out_prime;
  logic        out_overflow;

  int fail_count;
  int results_owed;
  int cycle_count = 0;
  // set during a stretch of back-to-back items with no idling on either side
  bit steady      = 1'b0;

  // corner start values
  logic [31:0] corner_starts [CORNER_ITEMS] = '{
    32'd0,          // zero gives two
    32'd1,          // one comes back as one, the first divisor already past the root
    32'd2,          // smallest even that gives itself
    32'd3,          // smallest odd prime
    32'd4,          // even above two, raised to five
    32'd8,          // raised to nine, composite, moves on to eleven
    32'd9,          // odd composite hit by three
    32'd24,         // two composites in a row before 29
    32'd25,         // hit by five
    32'd49,         // first wheel divisor
    32'd121,
    32'd169,
    32'd289,
    32'd361,
    32'd529,
    32'd841,        // hit by 29, the second-to-last wheel entry
    32'd961,
    32'd1369,       // divisor reached just after the wheel loops back
    32'd1681,       // looped wheel steps
    32'd2209,
    32'd65535,      // gives 65537, crosses the 16-bit boundary
    32'h00FF_FFFF,  // 24-bit all ones
    32'hFFFF_FFFF,  // top value, hit by three, then overflow
    32'hFFFF_FFFE,  // top even value, raised then overflow
    32'hFFFF_FFFC   // long search through a large composite into overflow
  };

  always #5 clk = ~clk;

  next_prime_search_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_value(in_start_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_prime     (out_prime),
    .out_overflow  (out_overflow)
  );

  next_prime_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_value(in_start_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_prime     (out_prime),
    .out_overflow  (out_overflow),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  // idle cycles for one item, none during the steady stretch
  function automatic int idle_cycles();
    if (steady) begin
      return 0;
    end
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // mostly small starts keep the trial division short; a few mid-sized ones
  // and the top values, which overflow once three divides them, reach the upper bits
  function automatic logic [31:0] random_start();
    int unsigned pick;
    int unsigned bits;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      return $urandom_range(0, 3);
    end
    if (pick < 8) begin
      return 32'hFFFF_FFFE | $urandom_range(0, 1);
    end
    bits = (pick < 20) ? $urandom_range(17, 22) : $urandom_range(1, 16);
    return $urandom & ((32'd1 << bits) - 32'd1);
  endfunction

  // offer one start value and hold it until it is taken; valid stays high
  // across back-to-back items
  task automatic offer_start(input logic [31:0] value);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int i;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners first
    for (i = 0; i < CORNER_ITEMS; i++) begin
      offer_start(corner_starts[i]);
    end

    // random part, with a stretch of no idling in the middle
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 40) && (i < 55);
      offer_start(random_start());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // let the owed count catch up with the last item, then drain
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[next_prime_search_core] OK");
    end else begin
      $display("[next_prime_search_core] ERROR");
    end
    $finish;
  end

  // result side: either ready goes up early and waits for the item, or it
  // holds off until the item is showing and then stalls on top of that
  initial begin : result_sink
    int stall;
    bit early;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_cycles();
      early = $urandom_range(0, 1);
      if (early) begin
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[next_prime_search_core] ERROR");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
rtl/core/nps_pkg.sv
rtl/core/nps_div.sv
rtl/core/next_prime_search_core.sv
bench/next_prime_checker.sv
bench/tb_next_prime_search_core.sv
